[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent-assertion wrappers, clocked on clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check, disabled while rst is high
`define SRW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication check
`define SRW_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  `SRW_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

[rtl/srw_pkg.sv]
// ---------------------------------------------------------------------------
// srw_pkg
// Types and constants of the selective-repeat receive window.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package srw_pkg;

  // Port field widths
  localparam int unsigned SEQ_W      = 5;
  localparam int unsigned PORT_PAY_W = 32;
  localparam int unsigned WIN_W      = 5;

  // Internal widths: sequence counter reaches 61, signed offset needs one more bit
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned OFF_W      = 7;
  localparam int unsigned EXT_PAY_W  = 64;

  // Register port
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic        REG_WINDOW = 1'b0;
  localparam logic [WIN_W-1:0] WINDOW_RESET = 5'd4;

  // Result kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_ACK  = 1'b1;

  // Control broadcast along the cell row
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

endpackage

[rtl/srw_if.sv]
// ---------------------------------------------------------------------------
// Stream interfaces
// Valid/ready channels for arriving frames and outgoing results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface srw_frame_if;
  logic                            valid;
  logic                            ready;
  logic [srw_pkg::SEQ_W-1:0]       frame_sequence;
  logic [srw_pkg::PORT_PAY_W-1:0]  frame_payload;

  modport source (output valid, frame_sequence, frame_payload, input ready);
  modport sink   (input valid, frame_sequence, frame_payload, output ready);
endinterface

interface srw_result_if;
  logic                            valid;
  logic                            ready;
  logic                            kind;
  logic [srw_pkg::PORT_PAY_W-1:0]  delivered_payload;
  logic [srw_pkg::SEQ_W-1:0]       ack_sequence;
  logic                            negative_ack;
  logic                            last;

  modport source (output valid, kind, delivered_payload, ack_sequence, negative_ack, last,
                  input ready);
  modport sink   (input valid, kind, delivered_payload, ack_sequence, negative_ack, last,
                  output ready);
endinterface

[rtl/srw_cell.sv]
// ---------------------------------------------------------------------------
// srw_cell
// One receive slot: valid flag and buffered payload, shifts down one per beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module srw_cell #(
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  srw_pkg::cell_ctrl_t     ctrl,
  input  logic                    store,
  input  logic [PAYLOAD_BITS-1:0] store_payload,
  input  logic                    up_valid,
  input  logic [PAYLOAD_BITS-1:0] up_payload,
  output logic                    valid,
  output logic [PAYLOAD_BITS-1:0] payload
);

  // Slot occupancy
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= up_valid;
    end else if (store) begin
      valid <= 1'b1;
    end
  end

  // Slot data, no reset
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      payload <= up_payload;
    end else if (store) begin
      payload <= store_payload;
    end
  end

endmodule

[rtl/selective_repeat_receive_window.sv]
// ---------------------------------------------------------------------------
// selective_repeat_receive_window
// The first result is registered in the cycle after the frame beat is accepted.
// Results: an out-of-order or rejected frame gives one NAK beat; an in-order
//   frame gives its data, the buffered successors and an ACK; no frame is taken meanwhile.
// Reset: window 4, expected sequence 0, all slots empty; writing the window
//   register also clears the expected sequence and the slots.
// Slots form a row of cells that shifts down one place per delivered beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module selective_repeat_receive_window #(
  parameter int unsigned WINDOW_MAX   = 16,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  srw_frame_if.sink                        frame,
  srw_result_if.source                     result,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [srw_pkg::PADDR_W-1:0]      paddr,
  input  logic [srw_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [srw_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);

  localparam int unsigned CNT_W = srw_pkg::CNT_W;
  localparam int unsigned OFF_W = srw_pkg::OFF_W;
  localparam int unsigned EXT_W = srw_pkg::EXT_PAY_W;
  localparam logic [OFF_W-1:0] WMAX_EXT = OFF_W'(WINDOW_MAX);

  srw_pkg::state_t state, state_next;

  logic [srw_pkg::WIN_W-1:0] window_size;
  logic [CNT_W-1:0]          exp_seq, exp_next, exp_inc;
  logic [CNT_W-1:0]          win_raw, win_eff, space;
  logic [OFF_W-1:0]          diff, offset;
  logic                      hit0, in_win;

  // Output register
  logic                                out_valid;
  logic                                out_kind, out_nak, out_last;
  logic [srw_pkg::PORT_PAY_W-1:0]      out_pay;
  logic [srw_pkg::SEQ_W-1:0]           out_ack;

  logic                                can_emit, frame_ready, acc;
  logic                                emit, e_kind, e_nak, e_last;
  logic [srw_pkg::PORT_PAY_W-1:0]      e_pay;
  logic [srw_pkg::SEQ_W-1:0]           e_ack;
  logic                                shift, store_en;

  logic                                cfg_wr;
  srw_pkg::cell_ctrl_t                 cell_ctrl;

  logic [EXT_W-1:0]                    frame_ext, frame_back, cell0_ext;
  logic [PAYLOAD_BITS-1:0]             frame_st;

  logic                                cell_valid [WINDOW_MAX];
  logic [PAYLOAD_BITS-1:0]             cell_pay   [WINDOW_MAX];
  logic                                up_valid   [WINDOW_MAX];
  logic [PAYLOAD_BITS-1:0]             up_pay     [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]               store_vec;

  // Register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite &&
                  (paddr[srw_pkg::PADDR_W-1:2] == srw_pkg::REG_WINDOW);
  assign prdata = (paddr[srw_pkg::PADDR_W-1:2] == srw_pkg::REG_WINDOW) ?
                  srw_pkg::APB_DATA_W'(window_size) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= srw_pkg::WINDOW_RESET;
    end else if (cfg_wr) begin
      window_size <= pwdata[srw_pkg::WIN_W-1:0];
    end
  end

  // Effective window: zero acts as one, clamp to WINDOW_MAX
  assign win_raw = (window_size == '0) ? CNT_W'(1) : CNT_W'(window_size);
  assign win_eff = ({1'b0, win_raw} > WMAX_EXT) ? WMAX_EXT[CNT_W-1:0] : win_raw;
  assign space   = {win_eff[CNT_W-2:0], 1'b0};

  // Offset of the frame from the expected sequence, wrapped into the space
  assign diff   = OFF_W'(frame.frame_sequence) - OFF_W'(exp_seq);
  assign offset = diff[OFF_W-1] ? (diff + OFF_W'(space)) : diff;
  assign hit0   = (offset == '0);
  assign in_win = !hit0 && (offset < OFF_W'(win_eff));

  assign exp_inc = ((exp_seq + CNT_W'(1)) == space) ? '0 : (exp_seq + CNT_W'(1));

  // Payload width conversions
  assign frame_ext  = EXT_W'(frame.frame_payload);
  assign frame_st   = frame_ext[PAYLOAD_BITS-1:0];
  assign frame_back = EXT_W'(frame_st);
  assign cell0_ext  = EXT_W'(cell_pay[0]);

  // Handshake
  assign can_emit    = !out_valid || result.ready;
  assign frame_ready = (state == srw_pkg::ST_IDLE) && can_emit;
  assign acc         = frame.valid && frame_ready;
  assign frame.ready = frame_ready;

  // Sequencer: one result beat per cycle unless the result port stalls
  always_comb begin
    state_next = state;
    exp_next   = exp_seq;
    emit       = 1'b0;
    e_kind     = srw_pkg::KIND_DATA;
    e_pay      = '0;
    e_ack      = '0;
    e_nak      = 1'b0;
    e_last     = 1'b0;
    shift      = 1'b0;
    store_en   = 1'b0;
    unique case (state)
      srw_pkg::ST_IDLE: begin
        if (acc) begin
          emit = 1'b1;
          if (hit0) begin
            e_pay      = frame_back[srw_pkg::PORT_PAY_W-1:0];
            shift      = 1'b1;
            exp_next   = exp_inc;
            state_next = srw_pkg::ST_DRAIN;
          end else begin
            e_kind   = srw_pkg::KIND_ACK;
            e_ack    = exp_seq[srw_pkg::SEQ_W-1:0];
            e_nak    = 1'b1;
            e_last   = 1'b1;
            store_en = in_win;
          end
        end
      end
      srw_pkg::ST_DRAIN: begin
        if (can_emit) begin
          emit = 1'b1;
          if (cell_valid[0]) begin
            e_pay    = cell0_ext[srw_pkg::PORT_PAY_W-1:0];
            shift    = 1'b1;
            exp_next = exp_inc;
          end else begin
            e_kind     = srw_pkg::KIND_ACK;
            e_ack      = exp_seq[srw_pkg::SEQ_W-1:0];
            e_last     = 1'b1;
            state_next = srw_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = srw_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= srw_pkg::ST_IDLE;
      exp_seq <= '0;
    end else begin
      state   <= state_next;
      exp_seq <= cfg_wr ? '0 : exp_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind <= e_kind;
      out_pay  <= e_pay;
      out_ack  <= e_ack;
      out_nak  <= e_nak;
      out_last <= e_last;
    end
  end

  assign result.valid             = out_valid;
  assign result.kind              = out_kind;
  assign result.delivered_payload = out_pay;
  assign result.ack_sequence      = out_ack;
  assign result.negative_ack      = out_nak;
  assign result.last              = out_last;

  // Cell row
  assign cell_ctrl.shift = shift;
  assign cell_ctrl.clear = cfg_wr;

  for (genvar j = 0; j < WINDOW_MAX; j++) begin : g_cell
    if (j == WINDOW_MAX - 1) begin : g_top
      assign up_valid[j] = 1'b0;
      assign up_pay[j]   = '0;
    end else begin : g_link
      assign up_valid[j] = cell_valid[j+1];
      assign up_pay[j]   = cell_pay[j+1];
    end

    assign store_vec[j] = store_en && (offset == OFF_W'(j));

    srw_cell #(
      .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .ctrl          (cell_ctrl),
      .store         (store_vec[j]),
      .store_payload (frame_st),
      .up_valid      (up_valid[j]),
      .up_payload    (up_pay[j]),
      .valid         (cell_valid[j]),
      .payload       (cell_pay[j])
    );
  end

  // Checks
  `SRW_ASSERT_IMPLIES(a_cell0_idle, state == srw_pkg::ST_IDLE, !cell_valid[0], "head cell full")
  `SRW_ASSERT(a_exp_in_space, exp_seq < space, "expected sequence outside sequence space")
  `SRW_ASSERT_IMPLIES(a_last_is_ack, out_valid, out_kind == out_last, "kind and last disagree")

endmodule

[dv/tb_selective_repeat_receive_window.sv]
// ---------------------------------------------------------------------------
// tb_selective_repeat_receive_window
// Drives arriving frames into the receive window and checks every result beat
// against a scoreboard that tracks the expected sequence and the buffered
// slots. A short directed run comes first. Random phases follow, each with a
// new window size and a chosen pattern of sender idling and receiver stalls.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_selective_repeat_receive_window;

  localparam int CYCLE_LIMIT = 500_000;
  localparam int HOLD_LEN    = 300;
  localparam int SETTLE      = 4;
  localparam int MAX_LINES   = 40;
  localparam logic [srw_pkg::PADDR_W-1:0] WINDOW_ADDR = {srw_pkg::REG_WINDOW, 2'b00};

  // Directed frames, starting from the reset window of four
  localparam int NUM_DIRECTED = 21;
  localparam logic [srw_pkg::SEQ_W-1:0] DIR_SEQ [NUM_DIRECTED] = '{
    5'd0, 5'd0, 5'd31, 5'd2, 5'd3, 5'd2, 5'd4, 5'd5, 5'd1, 5'd7, 5'd6,
    5'd5, 5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd8, 5'd7};
  localparam logic [srw_pkg::PORT_PAY_W-1:0] DIR_PAY [NUM_DIRECTED] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h5A5A_5A5A, 32'h1111_1111, 32'h2222_2222,
    32'h3333_3333, 32'h4444_4444, 32'h5555_5555, 32'h6666_6666, 32'h7777_7777,
    32'h8888_8888, 32'h9999_9999, 32'hAAAA_AAAA, 32'hBBBB_BBBB, 32'hCCCC_CCCC,
    32'hDDDD_DDDD, 32'hEEEE_EEEE, 32'h0123_4567, 32'h89AB_CDEF, 32'hA5A5_A5A5,
    32'hFFFF_0000};

  // Random phases: window written, sender idle %, receiver stall %, frames, hold-off, mid-phase pause
  localparam int NUM_PHASES = 9;
  localparam int PH_WINDOW [NUM_PHASES] = '{16, 1, 0, 31, 7, 2, 17, 9, 4};
  localparam int PH_IDLE   [NUM_PHASES] = '{0, 71, 0, 30, 71, 0, 30, 0, 71};
  localparam int PH_STALL  [NUM_PHASES] = '{0, 0, 71, 30, 0, 71, 30, 0, 0};
  localparam int PH_ITEMS  [NUM_PHASES] = '{60, 30, 30, 60, 50, 40, 40, 50, 40};
  localparam bit PH_HOLD   [NUM_PHASES] = '{1, 0, 0, 1, 0, 0, 0, 0, 0};
  localparam bit PH_PAUSE  [NUM_PHASES] = '{0, 0, 0, 0, 1, 0, 0, 0, 0};

  typedef struct packed {
    logic                           kind;
    logic [srw_pkg::PORT_PAY_W-1:0] payload;
    logic [srw_pkg::SEQ_W-1:0]      ack_seq;
    logic                           nak;
    logic                           last;
  } outcome_t;

  // Scoreboard: tracks the receiver's window and the results still owed
  class window_scoreboard;
    localparam int MAX_FRAMES = 16;

    int unsigned                    fail_count;
    logic [srw_pkg::WIN_W-1:0]      window_reg;
    int unsigned                    next_seq;
    bit                             slot_full [MAX_FRAMES];
    logic [srw_pkg::PORT_PAY_W-1:0] slot_word [MAX_FRAMES];
    outcome_t                       due_q [$];

    function new();
      fail_count = 0;
      window_reg = srw_pkg::WINDOW_RESET;
      restart();
    endfunction

    function void restart();
      next_seq = 0;
      foreach (slot_full[j]) slot_full[j] = 1'b0;
    endfunction

    function void write_window(logic [srw_pkg::WIN_W-1:0] value);
      window_reg = value;
      restart();
    endfunction

    // zero acts as one, anything above the slot count is clamped
    function int frames();
      if (window_reg == 0) return 1;
      if (window_reg > MAX_FRAMES) return MAX_FRAMES;
      return int'(window_reg);
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    function void add(logic kind, logic [srw_pkg::PORT_PAY_W-1:0] word, int unsigned seq,
                      logic nak, logic last);
      outcome_t o;
      o.kind    = kind;
      o.payload = word;
      o.ack_seq = srw_pkg::SEQ_W'(seq);
      o.nak     = nak;
      o.last    = last;
      due_q.push_back(o);
    endfunction

    // Work out the results of one accepted frame
    function void note_frame(logic [srw_pkg::SEQ_W-1:0] seq,
                             logic [srw_pkg::PORT_PAY_W-1:0] word);
      int n;
      int space;
      int off;
      int moved;
      n = frames();
      space = 2 * n;
      off = int'(seq) - int'(next_seq);
      if (off < 0) off += space;
      if (off == 0) begin
        add(srw_pkg::KIND_DATA, word, 0, 1'b0, 1'b0);
        next_seq = (next_seq + 1) % space;
        // hand up buffered successors while they run unbroken
        moved = 1;
        while (moved < n && slot_full[moved]) begin
          add(srw_pkg::KIND_DATA, slot_word[moved], 0, 1'b0, 1'b0);
          slot_full[moved] = 1'b0;
          next_seq = (next_seq + 1) % space;
          moved++;
        end
        // slide the window past everything delivered
        for (int j = 1; j < n; j++) begin
          if (j + moved < n) begin
            slot_full[j] = slot_full[j + moved];
            slot_word[j] = slot_word[j + moved];
          end else begin
            slot_full[j] = 1'b0;
          end
        end
        add(srw_pkg::KIND_ACK, '0, next_seq, 1'b0, 1'b1);
      end else begin
        if (off > 0 && off < n) begin
          slot_full[off] = 1'b1;
          slot_word[off] = word;
        end
        add(srw_pkg::KIND_ACK, '0, next_seq, 1'b1, 1'b1);
      end
    endfunction

    task report(string msg);
      fail_count++;
      if (fail_count <= MAX_LINES) $display("MISMATCH: %s", msg);
    endtask

    task check_result(outcome_t got);
      outcome_t want;
      if (due_q.size() == 0) begin
        report($sformatf("unexpected beat kind=%0d pay=%h seq=%0d nak=%0d last=%0d",
                         got.kind, got.payload, got.ack_seq, got.nak, got.last));
        return;
      end
      want = due_q.pop_front();
      if (got.kind !== want.kind || got.payload !== want.payload ||
          got.ack_seq !== want.ack_seq || got.nak !== want.nak ||
          got.last !== want.last)
        report($sformatf(
          "got kind=%0d pay=%h seq=%0d nak=%0d last=%0d, want %0d %h %0d %0d %0d",
          got.kind, got.payload, got.ack_seq, got.nak, got.last,
          want.kind, want.payload, want.ack_seq, want.nak, want.last));
    endtask
  endclass

  logic                           clk;
  logic                           rst;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [srw_pkg::PADDR_W-1:0]    paddr;
  logic [srw_pkg::APB_DATA_W-1:0] pwdata;
  logic [srw_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  srw_frame_if  frame_if ();
  srw_result_if result_if ();

  window_scoreboard sb = new();

  int sender_idle_pct;
  int recv_stall_pct;
  int hold_ticket;
  int hold_seen;
  int hold_left;
  int cycle_count;

  selective_repeat_receive_window dut (
    .clk     (clk),
    .rst     (rst),
    .frame   (frame_if),
    .result  (result_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested
  always @(negedge clk) begin
    if (hold_left > 0) begin
      result_if.ready <= 1'b0;
      hold_left--;
    end else if (hold_seen != hold_ticket) begin
      hold_seen = hold_ticket;
      hold_left = HOLD_LEN - 1;
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: check the result beat first, then predict from the frame beat
  always @(posedge clk) begin
    outcome_t got;
    if (rst === 1'b0) begin
      if (result_if.valid && result_if.ready) begin
        got.kind    = result_if.kind;
        got.payload = result_if.delivered_payload;
        got.ack_seq = result_if.ack_sequence;
        got.nak     = result_if.negative_ack;
        got.last    = result_if.last;
        sb.check_result(got);
      end
      if (frame_if.valid && frame_if.ready)
        sb.note_frame(frame_if.frame_sequence, frame_if.frame_payload);
    end
  end

  // All driving tasks start and end on a falling edge
  task idle_gap();
    while ($urandom_range(99) < sender_idle_pct) begin
      frame_if.valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  task offer_frame(input logic [srw_pkg::SEQ_W-1:0] seq,
                   input logic [srw_pkg::PORT_PAY_W-1:0] word);
    frame_if.valid          <= 1'b1;
    frame_if.frame_sequence <= seq;
    frame_if.frame_payload  <= word;
    do @(posedge clk); while (!frame_if.ready);
    @(negedge clk);
  endtask

  task wait_drained();
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Write the window register, then read it back
  task set_window(input int value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= WINDOW_ADDR;
    pwdata  <= srw_pkg::APB_DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_window(srw_pkg::WIN_W'(value));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== srw_pkg::APB_DATA_W'(value))
      sb.report($sformatf("window readback %h, wrote %0d", prdata, value));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly frames in or near the window, some arbitrary sequence numbers
  function logic [srw_pkg::SEQ_W-1:0] pick_sequence();
    int n;
    int r;
    int off;
    n = sb.frames();
    r = $urandom_range(99);
    if (r < 15) return srw_pkg::SEQ_W'($urandom_range(31));
    if (r < 38 || n == 1) off = 0;
    else off = $urandom_range(n - 1, 1);
    return srw_pkg::SEQ_W'((sb.next_seq + off) % (2 * n));
  endfunction

  initial begin
    rst             = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    frame_if.valid  = 1'b0;
    frame_if.frame_sequence = '0;
    frame_if.frame_payload  = '0;
    result_if.ready = 1'b0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_ticket     = 0;
    hold_seen       = 0;
    hold_left       = 0;
    cycle_count     = 0;

    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reordering, duplicates, wrap and out-of-window frames
    for (int i = 0; i < NUM_DIRECTED; i++)
      offer_frame(DIR_SEQ[i], DIR_PAY[i]);

    // Random phases
    for (int p = 0; p < NUM_PHASES; p++) begin
      frame_if.valid <= 1'b0;
      wait_drained();
      repeat (SETTLE) @(negedge clk);
      set_window(PH_WINDOW[p]);
      sender_idle_pct = PH_IDLE[p];
      recv_stall_pct  = PH_STALL[p];
      if (PH_HOLD[p]) hold_ticket++;
      for (int i = 0; i < PH_ITEMS[p]; i++) begin
        if (PH_PAUSE[p] && i == PH_ITEMS[p] / 2) begin
          frame_if.valid <= 1'b0;
          @(negedge clk);
          wait_drained();
        end
        idle_gap();
        offer_frame(pick_sequence(), $urandom());
      end
    end

    frame_if.valid <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
